/* sv/acrms_pkg.sv */
// Shared types, constants and width helpers for the AC RMS meter.
`default_nettype none

package acrms_pkg;

  // Field widths of the sample, the registers and the result.
  localparam int unsigned SampleW  = 12;
  localparam int unsigned AdcBits  = 12;
  localparam int unsigned MidW     = 12;
  localparam int unsigned WinLenW  = 11;
  localparam int unsigned GainW    = 24;
  localparam int unsigned SquelchW = 20;
  localparam int unsigned TrimW    = 18;
  localparam int unsigned OutW     = 20;
  localparam int unsigned QFrac    = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam int unsigned MaxWindowDefault = 1024;

  // Only the low converter bits of a sample take part.
  localparam logic [SampleW-1:0] SampleMask =
      (AdcBits >= SampleW) ? {SampleW{1'b1}} : SampleW'((1 << AdcBits) - 1);

  localparam logic [MidW-1:0]     MidReset     = MidW'(1650);
  localparam logic [WinLenW-1:0]  WinLenReset  = WinLenW'(200);
  localparam logic [GainW-1:0]    GainReset    = GainW'(65536);
  localparam logic [SquelchW-1:0] SquelchReset = SquelchW'(5000);
  localparam logic [TrimW-1:0]    TrimReset    = TrimW'(65536);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MID_OFFSET = 3'd0,
    CFG_WINDOW_LEN = 3'd1,
    CFG_GAIN       = 3'd2,
    CFG_SQUELCH    = 3'd3,
    CFG_TRIM       = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_GAIN,
    ST_TRIM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [SampleW-1:0] sample_mv;
  } sample_t;

  typedef struct packed {
    logic [OutW-1:0] rms_milli;
    logic            squelched;
    logic            clipped;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic sqrt_step;
    logic gain_en;
    logic trim_en;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic window_done;
    logic out_free;
  } ctrl_status_t;

  // Width of the effective window length, which can equal the maximum.
  function automatic int unsigned win_width(input int unsigned max_window);
    return $clog2(max_window + 1);
  endfunction

  // Width of the sample counter, which stays below the maximum window.
  function automatic int unsigned cnt_width(input int unsigned max_window);
    return $clog2(max_window);
  endfunction

  // Width of the square root of the full sum of squares.
  function automatic int unsigned root_width(input int unsigned max_window);
    return (2 * SampleW + $clog2(max_window) + 1) / 2;
  endfunction

endpackage

`default_nettype wire

/* sv/acrms_stream_if.sv */
// Valid/ready stream interface carrying one payload per transfer.
`default_nettype none

interface acrms_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/ac_rms_meter.sv */
// Top level of the AC RMS meter: configuration registers, controller, datapath.
//
//   Channel     Direction  Payload                              Role
//   sample_if   in         sample_mv[11:0]                      one converter sample
//   result_if   out        rms_milli[19:0], squelched, clipped  one result per window
//   cfg_*       in         cfg_idx_i[2:0], cfg_wdata_i[23:0]    register write port
//
// A sample that does not close the window is accumulated, and sample_if stays ready.
// A closing sample starts a serial divide of 2*R steps and a serial square root of
// R steps, R = ceil((24 + clog2(MAX_WINDOW)) / 2), followed by the gain, the trim
// and the result load; sample_if is not ready until the result has been loaded.
// Reset is asynchronous; it clears the sum and the count and returns every
// configuration register to its reset value at once.
// A result waits in its output register; samples keep flowing meanwhile. After the
// next window close, the next load holds off until that result has been transferred.
`default_nettype none

module ac_rms_meter #(
  parameter int unsigned MAX_WINDOW = acrms_pkg::MaxWindowDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  acrms_stream_if.sink                       sample_if,
  acrms_stream_if.source                     result_if,
  input  wire logic                          cfg_we_i,
  input  wire logic [acrms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [acrms_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import acrms_pkg::*;

  localparam int unsigned WinW = win_width(MAX_WINDOW);

  // Configuration registers. Writes to an index past the list are dropped, and
  // only the low bits of the write data that fit a register are kept.
  logic [MidW-1:0]     mid_q;
  logic [WinLenW-1:0]  win_len_q;
  logic [GainW-1:0]    gain_q;
  logic [SquelchW-1:0] squelch_q;
  logic [TrimW-1:0]    trim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q     <= MidReset;
      win_len_q <= WinLenReset;
      gain_q    <= GainReset;
      squelch_q <= SquelchReset;
      trim_q    <= TrimReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MID_OFFSET: mid_q     <= cfg_wdata_i[MidW-1:0];
        CFG_WINDOW_LEN: win_len_q <= cfg_wdata_i[WinLenW-1:0];
        CFG_GAIN:       gain_q    <= cfg_wdata_i[GainW-1:0];
        CFG_SQUELCH:    squelch_q <= cfg_wdata_i[SquelchW-1:0];
        CFG_TRIM:       trim_q    <= cfg_wdata_i[TrimW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective window: a length of zero acts as one, and a length beyond the
  // maximum window is held at the maximum. It also serves as the divisor.
  logic [WinW-1:0] win_eff;

  always_comb begin
    if (win_len_q == '0) begin
      win_eff = WinW'(1);
    end else if (32'(win_len_q) > MAX_WINDOW) begin
      win_eff = WinW'(MAX_WINDOW);
    end else begin
      win_eff = WinW'(win_len_q);
    end
  end

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         in_ready;
  sample_t      sample;
  result_t      result;
  logic         out_valid;

  assign sample          = sample_if.payload;
  assign sample_if.ready = in_ready;

  acrms_ctrl #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_if.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  acrms_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (sample),
    .mid_i       (mid_q),
    .win_i       (win_eff),
    .gain_i      (gain_q),
    .squelch_i   (squelch_q),
    .trim_i      (trim_q),
    .result_o    (result),
    .out_valid_o (out_valid),
    .out_ready_i (result_if.ready)
  );

  // The result register drives the output channel directly.
  assign result_if.valid   = out_valid;
  assign result_if.payload = result;

endmodule

`default_nettype wire

/* sv/acrms_ctrl.sv */
// Sequencing controller: accumulate, divide, square root, scale and emit.
`default_nettype none

module acrms_ctrl #(
  parameter int unsigned MAX_WINDOW = acrms_pkg::MaxWindowDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire acrms_pkg::ctrl_status_t status_i,
  output acrms_pkg::ctrl_cmd_t        cmd_o
);
  import acrms_pkg::*;

  localparam int unsigned RootW = root_width(MAX_WINDOW);
  localparam int unsigned NumW  = 2 * RootW;
  localparam int unsigned StepW = $clog2(NumW);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.window_done) begin
          state_d = ST_DIV;
          step_d  = StepW'(NumW - 1);
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_SQRT;
          step_d  = StepW'(RootW - 1);
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_GAIN;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      ST_GAIN: begin
        cmd_o.gain_en = 1'b1;
        state_d       = ST_TRIM;
      end
      ST_TRIM: begin
        cmd_o.trim_en = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  // A sample that completes the window must start the divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCUM && in_valid_i && status_i.window_done) |=> state_q == ST_DIV)
    else $error("window close did not start the divide");

  // The root phase runs exactly one step per result bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (32'(step_q) < RootW))
    else $error("root step count out of range");

endmodule

`default_nettype wire

/* sv/acrms_dp.sv */
// Datapath: square accumulation, serial divide and root, gain, squelch, trim.
`default_nettype none

module acrms_dp #(
  parameter int unsigned MAX_WINDOW = acrms_pkg::MaxWindowDefault
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire acrms_pkg::ctrl_cmd_t                              cmd_i,
  output acrms_pkg::ctrl_status_t                                status_o,
  input  wire acrms_pkg::sample_t                                sample_i,
  input  wire logic [acrms_pkg::MidW-1:0]                        mid_i,
  input  wire logic [acrms_pkg::win_width(MAX_WINDOW)-1:0]       win_i,
  input  wire logic [acrms_pkg::GainW-1:0]                       gain_i,
  input  wire logic [acrms_pkg::SquelchW-1:0]                    squelch_i,
  input  wire logic [acrms_pkg::TrimW-1:0]                       trim_i,
  output acrms_pkg::result_t                                     result_o,
  output logic                                                   out_valid_o,
  input  wire logic                                              out_ready_i
);
  import acrms_pkg::*;

  localparam int unsigned WinW    = win_width(MAX_WINDOW);
  localparam int unsigned CntW    = cnt_width(MAX_WINDOW);
  localparam int unsigned SumW    = 2 * SampleW + $clog2(MAX_WINDOW);
  localparam int unsigned RootW   = root_width(MAX_WINDOW);
  localparam int unsigned NumW    = 2 * RootW;
  localparam int unsigned GProdW  = RootW + GainW;
  localparam int unsigned ScaledW = GProdW - QFrac;
  localparam int unsigned TProdW  = ScaledW + TrimW;
  localparam int unsigned TrimmedW = TProdW - QFrac;

  // Accumulation.
  logic [SampleW-1:0]   sample;
  logic [SampleW-1:0]   diff;
  logic [2*SampleW-1:0] square;
  logic [SumW-1:0]      sum_q, sum_next;
  logic [CntW-1:0]      cnt_q;
  logic                 win_done;

  assign sample   = sample_i.sample_mv & SampleMask;
  assign diff     = (sample >= mid_i) ? (sample - mid_i) : (mid_i - sample);
  assign square   = {{SampleW{1'b0}}, diff} * {{SampleW{1'b0}}, diff};
  assign sum_next = sum_q + SumW'(square);
  assign win_done = (32'(cnt_q) + 32'd1) >= 32'(win_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accept) begin
      if (win_done) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_next;
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // Shared shift register: dividend, then quotient, then root radicand.
  logic [NumW-1:0]  num_q, num_d;
  logic [WinW-1:0]  drem_q, drem_d;
  logic [WinW:0]    drem_shift, drem_sub;
  logic             div_ge;
  logic [RootW:0]   srem_q, srem_d;
  logic [RootW+2:0] srem_shift, srem_sub, trial;
  logic             sqrt_ge;
  logic [RootW-1:0] root_q, root_d;

  assign drem_shift = {drem_q, num_q[NumW-1]};
  assign drem_sub   = drem_shift - {1'b0, win_i};
  assign div_ge     = drem_shift >= {1'b0, win_i};

  assign srem_shift = {srem_q, num_q[NumW-1:NumW-2]};
  assign trial      = {1'b0, root_q, 2'b01};
  assign srem_sub   = srem_shift - trial;
  assign sqrt_ge    = srem_shift >= trial;

  always_comb begin
    num_d  = num_q;
    drem_d = drem_q;
    srem_d = srem_q;
    root_d = root_q;
    if (cmd_i.accept && win_done) begin
      num_d  = NumW'(sum_next);
      drem_d = '0;
      srem_d = '0;
      root_d = '0;
    end else if (cmd_i.div_step) begin
      num_d  = {num_q[NumW-2:0], div_ge};
      drem_d = div_ge ? drem_sub[WinW-1:0] : drem_shift[WinW-1:0];
    end else if (cmd_i.sqrt_step) begin
      num_d  = {num_q[NumW-3:0], 2'b00};
      srem_d = sqrt_ge ? srem_sub[RootW:0] : srem_shift[RootW:0];
      root_d = {root_q[RootW-2:0], sqrt_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    drem_q <= drem_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  // Gain with squelch, then trim, each product registered.
  logic [GProdW-1:0]   gain_prod;
  logic [ScaledW-1:0]  scaled;
  logic [ScaledW-1:0]  scaled_q;
  logic                squelch_q;
  logic [TProdW-1:0]   trim_prod;
  logic [TrimmedW-1:0] trimmed_q;
  logic                clip;

  assign gain_prod = GProdW'(root_q) * GProdW'(gain_i);
  assign scaled    = gain_prod[GProdW-1:QFrac];
  assign trim_prod = TProdW'(scaled_q) * TProdW'(trim_i);
  assign clip      = trimmed_q > TrimmedW'({OutW{1'b1}});

  always_ff @(posedge clk_i) begin
    if (cmd_i.gain_en) begin
      if (ScaledW'(squelch_i) > scaled) begin
        scaled_q  <= '0;
        squelch_q <= 1'b1;
      end else begin
        scaled_q  <= scaled;
        squelch_q <= 1'b0;
      end
    end
    if (cmd_i.trim_en) begin
      trimmed_q <= trim_prod[TProdW-1:QFrac];
    end
  end

  // Output register.
  logic    out_valid_q;
  result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_q.rms_milli <= clip ? {OutW{1'b1}} : trimmed_q[OutW-1:0];
      result_q.squelched <= squelch_q;
      result_q.clipped   <= clip;
    end
  end

  assign result_o             = result_q;
  assign out_valid_o          = out_valid_q;
  assign status_o.window_done = win_done;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  // A squelched result is zero and can never be clipped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.squelched) |->
      (result_q.rms_milli == '0 && !result_q.clipped))
    else $error("squelched result is not zero");

  // The sample count always closes before the maximum window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) < MAX_WINDOW)
    else $error("sample count reached the maximum window");

endmodule

`default_nettype wire
